// File: rtl/ibm_pkg.sv
// Shared types and constants for the interpixel boundary mask block.
// Used by the core and the testbench. No dependencies.
package ibm_pkg;

    localparam int MAX_COLS_DEF = 4096;
    localparam int MAX_ROWS_DEF = 4096;

    localparam int LABEL_W  = 32;
    localparam int SIZE_W   = 13;
    localparam int MASK_W   = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LABEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS   = 2'd2;

    localparam logic [LABEL_W-1:0] REGION_LABEL_RST = 32'd1;
    localparam logic [SIZE_W-1:0]  IMAGE_COLS_RST   = 13'd4096;
    localparam logic [SIZE_W-1:0]  IMAGE_ROWS_RST   = 13'd4096;

    // which mask row of an image pixel is being emitted
    typedef enum logic [1:0] {
        ROW_EVEN = 2'd0,
        ROW_ODD  = 2'd1,
        ROW_LAST = 2'd2
    } row_sel_t;

    // which mask column of an image pixel is being emitted
    typedef enum logic [1:0] {
        COL_EVEN = 2'd0,
        COL_ODD  = 2'd1,
        COL_LAST = 2'd2
    } col_sel_t;

    typedef struct packed {
        logic [LABEL_W-1:0] pixel_label;
    } pix_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] out_col;
        logic [MASK_W-1:0] out_row;
        logic              is_boundary;
        logic              frame_done;
        logic [MASK_W-1:0] box_lo_col;
        logic [MASK_W-1:0] box_lo_row;
        logic [MASK_W-1:0] box_hi_col;
        logic [MASK_W-1:0] box_hi_row;
    } mask_item_t;

endpackage

// File: rtl/ibm_stream_if.sv
// Valid/ready stream channel carrying one item of a type chosen per instance.
// Item types come from ibm_pkg.
interface ibm_stream_if #(
    parameter type item_t = logic
) ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ibm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read and a write to the same entry in one cycle return the old data.
module ibm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/interpixel_boundary_mask_core.sv
// Crack-edge boundary mask of one labeled region, with running bounding box.
// Depends on ibm_pkg, ibm_stream_if and ibm_ram.
//
//   channel | dir | payload      | per item
//   --------+-----+--------------+------------------------------------------
//   pix     | in  | pix_item_t   | one label pixel, raster order
//   mask    | out | mask_item_t  | one mask pixel plus bounding box
//   cfg_*   | in  | index, data  | register write, one per cycle, no wait
//
// Each pixel yields 4 mask items, 6 on the last column, 6 on the last row and
// 9 on the last pixel; the single output register emits one item per cycle
// while mask is ready. Pixels pass a compare/read stage (line RAM read), then
// the emit sequencer; a new pixel is taken while the previous one is emitted.
// After reset the line RAM holds no valid data; the first row ignores its read data.
// A stall on mask holds the output register and backs up into pix.ready.
module interpixel_boundary_mask_core #(
    parameter int MAX_COLS = ibm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = ibm_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ibm_stream_if.sink                          pix,
    ibm_stream_if.source                        mask,
    input  logic                                cfg_we,
    input  logic [ibm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ibm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CSZ_W  = $clog2(MAX_COLS + 1);
    localparam int RSZ_W  = $clog2(MAX_ROWS + 1);
    localparam int BC_W   = $clog2(2 * MAX_COLS + 3);
    localparam int BR_W   = $clog2(2 * MAX_ROWS + 3);
    localparam int MASK_W = ibm_pkg::MASK_W;

    localparam int RST_COLS = (int'(ibm_pkg::IMAGE_COLS_RST) > MAX_COLS) ? MAX_COLS
                              : int'(ibm_pkg::IMAGE_COLS_RST);
    localparam int RST_ROWS = (int'(ibm_pkg::IMAGE_ROWS_RST) > MAX_ROWS) ? MAX_ROWS
                              : int'(ibm_pkg::IMAGE_ROWS_RST);
    localparam logic [BC_W-1:0] BOX_MIN_COL_RST = BC_W'(2 * RST_COLS + 2);
    localparam logic [BR_W-1:0] BOX_MIN_ROW_RST = BR_W'(2 * RST_ROWS + 2);

    // configuration
    logic [ibm_pkg::LABEL_W-1:0] region_label_reg;
    logic [ibm_pkg::SIZE_W-1:0]  image_cols_reg;
    logic [ibm_pkg::SIZE_W-1:0]  image_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_label_reg <= ibm_pkg::REGION_LABEL_RST;
            image_cols_reg   <= ibm_pkg::IMAGE_COLS_RST;
            image_rows_reg   <= ibm_pkg::IMAGE_ROWS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ibm_pkg::REG_REGION_LABEL: region_label_reg <= cfg_data;
                ibm_pkg::REG_IMAGE_COLS:
                    image_cols_reg <= cfg_data[ibm_pkg::SIZE_W-1:0];
                ibm_pkg::REG_IMAGE_ROWS:
                    image_rows_reg <= cfg_data[ibm_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective image size, clamped to 1..MAX
    logic [CSZ_W-1:0] cols_eff;
    logic [RSZ_W-1:0] rows_eff;

    always_comb
    begin
        if (image_cols_reg == '0)
            cols_eff = CSZ_W'(1);
        else if (int'(image_cols_reg) > MAX_COLS)
            cols_eff = CSZ_W'(MAX_COLS);
        else
            cols_eff = CSZ_W'(image_cols_reg);

        if (image_rows_reg == '0)
            rows_eff = RSZ_W'(1);
        else if (int'(image_rows_reg) > MAX_ROWS)
            rows_eff = RSZ_W'(MAX_ROWS);
        else
            rows_eff = RSZ_W'(image_rows_reg);
    end

    // ---------------- accept stage: position, match, line RAM access
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic             west_reg;
    logic             nw_reg;

    logic             j1_valid_reg;
    logic [COL_W-1:0] j1_c_reg;
    logic [ROW_W-1:0] j1_r_reg;
    logic             j1_m_reg, j1_w_reg, j1_last_c_reg, j1_last_r_reg, j1_first_reg;
    logic [CSZ_W-1:0] j1_cols_reg;
    logic [RSZ_W-1:0] j1_rows_reg;

    logic             j2_valid_reg;
    logic [COL_W-1:0] j2_c_reg;
    logic [ROW_W-1:0] j2_r_reg;
    logic             j2_m_reg, j2_n_reg, j2_w_reg, j2_nw_reg;
    logic             j2_last_c_reg, j2_last_r_reg, j2_first_reg;
    logic [CSZ_W-1:0] j2_cols_reg;
    logic [RSZ_W-1:0] j2_rows_reg;
    ibm_pkg::row_sel_t j2_row_reg, j2_row_next;
    ibm_pkg::col_sel_t j2_col_reg, j2_col_next;

    logic             out_valid_reg;
    ibm_pkg::mask_item_t out_item_reg;

    logic [COL_W-1:0] cur_c;
    logic [ROW_W-1:0] cur_r;
    logic             cur_m, cur_last_c, cur_last_r, restart;
    logic             pix_acc, j1_move, j2_free, emit, out_free, step_final;
    logic             line_north;
    logic             north_gated;

    assign restart = (CSZ_W'(col_cnt_reg) >= cols_eff) || (RSZ_W'(row_cnt_reg) >= rows_eff);
    assign cur_c   = restart ? '0 : col_cnt_reg;
    assign cur_r   = restart ? '0 : row_cnt_reg;
    assign cur_m   = (pix.data.pixel_label == region_label_reg);
    assign cur_last_c = ((CSZ_W'(cur_c) + CSZ_W'(1)) == cols_eff);
    assign cur_last_r = ((RSZ_W'(cur_r) + RSZ_W'(1)) == rows_eff);

    always_comb
    begin
        if (cur_last_c)
        begin
            col_cnt_next = '0;
            row_cnt_next = cur_last_r ? '0 : cur_r + ROW_W'(1);
        end
        else
        begin
            col_cnt_next = cur_c + COL_W'(1);
            row_cnt_next = cur_r;
        end
    end

    assign out_free  = !out_valid_reg || mask.ready;
    assign emit      = j2_valid_reg && out_free;
    assign j2_free   = !j2_valid_reg || (emit && step_final);
    assign j1_move   = j1_valid_reg && j2_free;
    assign pix.ready = !j1_valid_reg || j1_move;
    assign pix_acc   = pix.valid && pix.ready;

    // read-first RAM: the same-cycle write to this column is seen by the next row only
    ibm_ram #(
        .WIDTH (1),
        .DEPTH (MAX_COLS)
    ) u_line (
        .clk     (clk),
        .wr_en   (pix_acc),
        .wr_addr (cur_c),
        .wr_data (cur_m),
        .rd_en   (pix_acc),
        .rd_addr (cur_c),
        .rd_data (line_north)
    );

    assign north_gated = (j1_r_reg != '0) ? line_north : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            west_reg     <= 1'b0;
            nw_reg       <= 1'b0;
            j1_valid_reg <= 1'b0;
            j2_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_acc)
            begin
                col_cnt_reg  <= col_cnt_next;
                row_cnt_reg  <= row_cnt_next;
                west_reg     <= cur_m;
                j1_valid_reg <= 1'b1;
            end
            else if (j1_move)
            begin
                j1_valid_reg <= 1'b0;
            end

            if (j1_move)
            begin
                nw_reg       <= north_gated;
                j2_valid_reg <= 1'b1;
            end
            else if (emit && step_final)
            begin
                j2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            j1_c_reg      <= cur_c;
            j1_r_reg      <= cur_r;
            j1_m_reg      <= cur_m;
            j1_w_reg      <= (cur_c != '0) ? west_reg : 1'b0;
            j1_last_c_reg <= cur_last_c;
            j1_last_r_reg <= cur_last_r;
            j1_first_reg  <= (cur_c == '0) && (cur_r == '0);
            j1_cols_reg   <= cols_eff;
            j1_rows_reg   <= rows_eff;
        end
        if (j1_move)
        begin
            j2_c_reg      <= j1_c_reg;
            j2_r_reg      <= j1_r_reg;
            j2_m_reg      <= j1_m_reg;
            j2_n_reg      <= north_gated;
            j2_w_reg      <= j1_w_reg;
            j2_nw_reg     <= (j1_c_reg != '0) ? nw_reg : 1'b0;
            j2_last_c_reg <= j1_last_c_reg;
            j2_last_r_reg <= j1_last_r_reg;
            j2_first_reg  <= j1_first_reg;
            j2_cols_reg   <= j1_cols_reg;
            j2_rows_reg   <= j1_rows_reg;
        end
    end

    // ---------------- emit sequencer
    logic [BC_W-1:0] emit_col;
    logic [BR_W-1:0] emit_row;
    logic            emit_bit, emit_done, first_step, col_wrap;
    logic [BC_W-1:0] box_min_col_reg, box_min_col_next, base_min_col;
    logic [BR_W-1:0] box_min_row_reg, box_min_row_next, base_min_row;
    logic [BC_W-1:0] box_max_col_reg, box_max_col_next, base_max_col;
    logic [BR_W-1:0] box_max_row_reg, box_max_row_next, base_max_row;
    logic [2:0]      touch_cnt;

    assign touch_cnt = 3'(j2_m_reg) + 3'(j2_n_reg) + 3'(j2_w_reg) + 3'(j2_nw_reg);

    always_comb
    begin
        case (j2_col_reg)
            ibm_pkg::COL_EVEN: emit_col = BC_W'({j2_c_reg, 1'b0});
            ibm_pkg::COL_ODD:  emit_col = BC_W'({j2_c_reg, 1'b1});
            default:           emit_col = BC_W'({j2_cols_reg, 1'b0});
        endcase

        case (j2_row_reg)
            ibm_pkg::ROW_EVEN: emit_row = BR_W'({j2_r_reg, 1'b0});
            ibm_pkg::ROW_ODD:  emit_row = BR_W'({j2_r_reg, 1'b1});
            default:           emit_row = BR_W'({j2_rows_reg, 1'b0});
        endcase

        emit_bit = 1'b0;
        case (j2_row_reg)
            ibm_pkg::ROW_EVEN:
            begin
                case (j2_col_reg)
                    ibm_pkg::COL_EVEN: emit_bit = (touch_cnt != 3'd0) && (touch_cnt != 3'd4);
                    ibm_pkg::COL_ODD:  emit_bit = j2_n_reg ^ j2_m_reg;
                    default:           emit_bit = j2_n_reg | j2_m_reg;
                endcase
            end
            ibm_pkg::ROW_ODD:
            begin
                case (j2_col_reg)
                    ibm_pkg::COL_EVEN: emit_bit = j2_w_reg ^ j2_m_reg;
                    ibm_pkg::COL_ODD:  emit_bit = 1'b0;   // odd/odd is never an edge
                    default:           emit_bit = j2_m_reg;
                endcase
            end
            default:
            begin
                case (j2_col_reg)
                    ibm_pkg::COL_EVEN: emit_bit = j2_w_reg | j2_m_reg;
                    default:           emit_bit = j2_m_reg;
                endcase
            end
        endcase

        emit_done = (j2_row_reg == ibm_pkg::ROW_LAST) && (j2_col_reg == ibm_pkg::COL_LAST);

        // step order: even/odd columns, then the closing column on the last pixel of a row
        col_wrap = (j2_col_reg == ibm_pkg::COL_LAST)
                   || ((j2_col_reg == ibm_pkg::COL_ODD) && !j2_last_c_reg);
        step_final = col_wrap && ((j2_row_reg == ibm_pkg::ROW_LAST)
                   || ((j2_row_reg == ibm_pkg::ROW_ODD) && !j2_last_r_reg));

        if (col_wrap)
        begin
            j2_col_next = ibm_pkg::COL_EVEN;
            case (j2_row_reg)
                ibm_pkg::ROW_EVEN: j2_row_next = ibm_pkg::ROW_ODD;
                ibm_pkg::ROW_ODD:
                begin
                    // closing row only below the last image row
                    if (j2_last_r_reg)
                        j2_row_next = ibm_pkg::ROW_LAST;
                    else
                        j2_row_next = ibm_pkg::ROW_EVEN;
                end
                default:           j2_row_next = ibm_pkg::ROW_EVEN;
            endcase
        end
        else
        begin
            j2_row_next = j2_row_reg;
            case (j2_col_reg)
                ibm_pkg::COL_EVEN: j2_col_next = ibm_pkg::COL_ODD;
                default:           j2_col_next = ibm_pkg::COL_LAST;
            endcase
        end

        // the box restarts on the first item of a frame
        first_step = j2_first_reg && (j2_row_reg == ibm_pkg::ROW_EVEN)
                     && (j2_col_reg == ibm_pkg::COL_EVEN);
        if (first_step)
        begin
            base_min_col = BC_W'({j2_cols_reg, 1'b0}) + BC_W'(2);
            base_min_row = BR_W'({j2_rows_reg, 1'b0}) + BR_W'(2);
            base_max_col = '0;
            base_max_row = '0;
        end
        else
        begin
            base_min_col = box_min_col_reg;
            base_min_row = box_min_row_reg;
            base_max_col = box_max_col_reg;
            base_max_row = box_max_row_reg;
        end

        box_min_col_next = base_min_col;
        box_min_row_next = base_min_row;
        box_max_col_next = base_max_col;
        box_max_row_next = base_max_row;
        if (emit_bit)
        begin
            if (emit_col < base_min_col) box_min_col_next = emit_col;
            if (emit_row < base_min_row) box_min_row_next = emit_row;
            if (emit_col > base_max_col) box_max_col_next = emit_col;
            if (emit_row > base_max_row) box_max_row_next = emit_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j2_row_reg      <= ibm_pkg::ROW_EVEN;
            j2_col_reg      <= ibm_pkg::COL_EVEN;
            box_min_col_reg <= BOX_MIN_COL_RST;
            box_min_row_reg <= BOX_MIN_ROW_RST;
            box_max_col_reg <= '0;
            box_max_row_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                j2_row_reg      <= j2_row_next;
                j2_col_reg      <= j2_col_next;
                box_min_col_reg <= box_min_col_next;
                box_min_row_reg <= box_min_row_next;
                box_max_col_reg <= box_max_col_next;
                box_max_row_reg <= box_max_row_next;
                out_valid_reg   <= 1'b1;
            end
            else if (mask.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg.out_col     <= MASK_W'(emit_col);
            out_item_reg.out_row     <= MASK_W'(emit_row);
            out_item_reg.is_boundary <= emit_bit;
            out_item_reg.frame_done  <= emit_done;
            out_item_reg.box_lo_col  <= MASK_W'(box_min_col_next);
            out_item_reg.box_lo_row  <= MASK_W'(box_min_row_next);
            out_item_reg.box_hi_col  <= MASK_W'(box_max_col_next);
            out_item_reg.box_hi_row  <= MASK_W'(box_max_row_next);
        end
    end

    assign mask.valid = out_valid_reg;
    assign mask.data  = out_item_reg;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for interpixel_boundary_mask_core: label pixels in, mask items out.
// Depends on ibm_pkg, ibm_stream_if and the core RTL. The expected mask items come from
// a built-in predictor of the line buffer, the crack-edge rules and the bounding box.
module tb_top;

    localparam int LABEL_W    = ibm_pkg::LABEL_W;
    localparam int SIZE_W     = ibm_pkg::SIZE_W;
    localparam int MASK_W     = ibm_pkg::MASK_W;
    localparam int CFG_DATA_W = ibm_pkg::CFG_DATA_W;
    localparam int MAX_COLS   = ibm_pkg::MAX_COLS_DEF;
    localparam int MAX_ROWS   = ibm_pkg::MAX_ROWS_DEF;

    localparam int RANDOM_PIXELS = 430;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 160;
    localparam int SETTLE_CYCLES = 12;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [ibm_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]           cfg_data;

    ibm_stream_if #(.item_t(ibm_pkg::pix_item_t))  pix_ch ();
    ibm_stream_if #(.item_t(ibm_pkg::mask_item_t)) mask_ch ();

    interpixel_boundary_mask_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .mask      (mask_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies seen by the predictor
    logic [LABEL_W-1:0] cfg_label = ibm_pkg::REGION_LABEL_RST;
    logic [SIZE_W-1:0]  cfg_cols  = ibm_pkg::IMAGE_COLS_RST;
    logic [SIZE_W-1:0]  cfg_rows  = ibm_pkg::IMAGE_ROWS_RST;

    // predictor state
    int col_cnt = 0;
    int row_cnt = 0;
    bit north_line [MAX_COLS];
    bit line_written [MAX_COLS];
    bit west_bit = 0;
    bit nw_bit   = 0;
    int box_min_col = 2 * MAX_COLS + 2;
    int box_min_row = 2 * MAX_ROWS + 2;
    int box_max_col = 0;
    int box_max_row = 0;

    logic [LABEL_W-1:0]  label_feed [$];
    ibm_pkg::mask_item_t expected_masks [$];

    bit idle_on     = 0;
    int holds_asked = 0;
    int pixels_in   = 0;
    int masks_seen  = 0;
    int frames_seen = 0;
    int mismatches  = 0;
    int reg_writes  = 0;
    int cycles      = 0;

    function automatic int clamp_size(logic [SIZE_W-1:0] v, int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    task automatic push_mask_pixel(int mc, int mr, bit b, bit done);
        ibm_pkg::mask_item_t it;
        if (b)
        begin
            if (box_min_col > mc) box_min_col = mc;
            if (box_min_row > mr) box_min_row = mr;
            if (box_max_col < mc) box_max_col = mc;
            if (box_max_row < mr) box_max_row = mr;
        end
        it.out_col     = mc[MASK_W-1:0];
        it.out_row     = mr[MASK_W-1:0];
        it.is_boundary = b;
        it.frame_done  = done;
        it.box_lo_col  = box_min_col[MASK_W-1:0];
        it.box_lo_row  = box_min_row[MASK_W-1:0];
        it.box_hi_col  = box_max_col[MASK_W-1:0];
        it.box_hi_row  = box_max_row[MASK_W-1:0];
        expected_masks.insert(expected_masks.size(), it);
    endtask

    // all mask items one label pixel produces, in emission order
    task automatic predict_crack_edges(logic [LABEL_W-1:0] lbl);
        int ncols, nrows, c, r, mc, mr, cnt;
        bit m, n, w, nw, last_c, last_r;
        ncols = clamp_size(cfg_cols, MAX_COLS);
        nrows = clamp_size(cfg_rows, MAX_ROWS);
        if (col_cnt >= ncols || row_cnt >= nrows)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        c = col_cnt;
        r = row_cnt;
        if (c == 0 && r == 0)
        begin
            box_min_col = 2 * ncols + 2;
            box_min_row = 2 * nrows + 2;
            box_max_col = 0;
            box_max_row = 0;
        end
        m  = (lbl == cfg_label);
        n  = (r > 0) ? north_line[c] : 1'b0;
        w  = (c > 0) ? west_bit : 1'b0;
        nw = (c > 0) ? nw_bit : 1'b0;
        last_c = (c + 1 == ncols);
        last_r = (r + 1 == nrows);
        mc  = 2 * c;
        mr  = 2 * r;
        cnt = int'(m) + int'(n) + int'(w) + int'(nw);

        push_mask_pixel(mc, mr, cnt > 0 && cnt < 4, 1'b0);
        push_mask_pixel(mc + 1, mr, n != m, 1'b0);
        if (last_c) push_mask_pixel(2 * ncols, mr, n || m, 1'b0);
        push_mask_pixel(mc, mr + 1, w != m, 1'b0);
        push_mask_pixel(mc + 1, mr + 1, 1'b0, 1'b0);
        if (last_c) push_mask_pixel(2 * ncols, mr + 1, m, 1'b0);
        if (last_r)
        begin
            push_mask_pixel(mc, 2 * nrows, w || m, 1'b0);
            push_mask_pixel(mc + 1, 2 * nrows, m, 1'b0);
            if (last_c) push_mask_pixel(2 * ncols, 2 * nrows, m, 1'b1);
        end

        north_line[c]   = m;
        line_written[c] = 1'b1;
        nw_bit   = n;
        west_bit = m;
        if (last_c)
        begin
            col_cnt = 0;
            row_cnt = last_r ? 0 : r + 1;
        end
        else
            col_cnt = c + 1;
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // label pixel driver
    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        int gap_left;
        if (!rst_n)
        begin
            pix_ch.valid <= 1'b0;
            pix_ch.data  <= '0;
            gap_left = 0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                predict_crack_edges(pix_ch.data.pixel_label);
                pixels_in++;
            end
            if (!pix_ch.valid || pix_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pix_ch.valid <= 1'b0;
                end
                else if (label_feed.size() != 0)
                begin
                    pix_ch.valid            <= 1'b1;
                    pix_ch.data.pixel_label <= label_feed.pop_front();
                    if (idle_on && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 10);
                end
                else
                    pix_ch.valid <= 1'b0;
            end
        end
    end

    // mask item monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : mask_monitor
        int stall_left;
        int hold_left;
        int holds_done;
        ibm_pkg::mask_item_t want;
        ibm_pkg::mask_item_t got;
        if (!rst_n)
        begin
            mask_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            holds_done = 0;
        end
        else
        begin
            if (mask_ch.valid && mask_ch.ready)
            begin
                got = mask_ch.data;
                masks_seen++;
                if (got.frame_done)
                    frames_seen++;
                if (expected_masks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 40)
                        $display("%0t: unexpected mask item at row %0d col %0d",
                                 $time, got.out_row, got.out_col);
                end
                else
                begin
                    want = expected_masks.pop_front();
                    check_field("out_col", 32'(want.out_col), 32'(got.out_col));
                    check_field("out_row", 32'(want.out_row), 32'(got.out_row));
                    check_field("is_boundary", 32'(want.is_boundary), 32'(got.is_boundary));
                    check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
                    check_field("box_lo_col", 32'(want.box_lo_col), 32'(got.box_lo_col));
                    check_field("box_lo_row", 32'(want.box_lo_row), 32'(got.box_lo_row));
                    check_field("box_hi_col", 32'(want.box_hi_col), 32'(got.box_hi_col));
                    check_field("box_hi_row", 32'(want.box_hi_row), 32'(got.box_hi_row));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                mask_ch.ready <= 1'b0;
            end
            else if (holds_done != holds_asked)
            begin
                // long back-pressure: the core fills and stops taking pixels
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                mask_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                mask_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                mask_ch.ready <= 1'b0;
            end
            else
                mask_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d mask items pending",
                     cycles, expected_masks.size());
            $display("interpixel_boundary_mask_core: mismatch");
            $finish;
        end
    end

    task automatic feed_label(logic [LABEL_W-1:0] v);
        label_feed.insert(label_feed.size(), v);
    endtask

    task automatic write_reg(logic [ibm_pkg::CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        reg_writes++;
        case (idx)
            ibm_pkg::REG_REGION_LABEL: cfg_label = val;
            ibm_pkg::REG_IMAGE_COLS:   cfg_cols  = val[SIZE_W-1:0];
            ibm_pkg::REG_IMAGE_ROWS:   cfg_rows  = val[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // Called only with the core idle. If the frame would carry on into line buffer
    // entries never written, rows is pulled down so the next pixel restarts the frame.
    task automatic configure(logic [LABEL_W-1:0] lbl, logic [SIZE_W-1:0] cols,
                             logic [SIZE_W-1:0] rows);
        int nc, nr, c;
        bit clash;
        nc = clamp_size(cols, MAX_COLS);
        nr = clamp_size(rows, MAX_ROWS);
        clash = 1'b0;
        if (row_cnt > 0 && col_cnt < nc && row_cnt < nr)
            for (c = col_cnt; c < nc; c++)
                if (!line_written[c])
                    clash = 1'b1;
        if (clash)
            rows = row_cnt[SIZE_W-1:0];
        write_reg(ibm_pkg::REG_REGION_LABEL, lbl);
        write_reg(ibm_pkg::REG_IMAGE_COLS, CFG_DATA_W'(cols));
        write_reg(ibm_pkg::REG_IMAGE_ROWS, CFG_DATA_W'(rows));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (label_feed.size() != 0 || pix_ch.valid || expected_masks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [LABEL_W-1:0] pick_label(int match_pct);
        if ($urandom_range(0, 99) < match_pct)
            return cfg_label;
        case ($urandom_range(0, 3))
            0: return cfg_label ^ (32'h1 << $urandom_range(0, 31));
            1: return $urandom;
            2: return cfg_label + 32'd1;
            default: return ~cfg_label;
        endcase
    endfunction

    function automatic logic [LABEL_W-1:0] pick_region();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_big();
        case ($urandom_range(0, 2))
            0: return 13'd4096;
            1: return 13'd8191;
            default: return SIZE_W'($urandom_range(64, 4095));
        endcase
    endfunction

    initial
    begin : stimulus
        int random_pixels;
        int n, i, match_pct, kind;
        logic [SIZE_W-1:0] cols, rows;
        random_pixels = 0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: label 1 on a 4096-wide image, first row only
        feed_label(32'd1);
        feed_label(32'hFFFF_FFFF);
        wait_idle();

        // size 0 acts as 1: single-pixel frames, wrap, and a frame with no boundary
        configure(32'h0, 13'd0, 13'd0);
        feed_label(32'h0000_0000);
        feed_label(32'hFFFF_FFFF);
        wait_idle();

        // oversize registers clamp to the maximum
        configure(32'hFFFF_FFFF, 13'd8191, 13'd8191);
        feed_label(32'hFFFF_FFFF);
        feed_label(32'h0000_0000);
        feed_label(32'hFFFF_FFFE);
        feed_label(32'hFFFF_FFFF);
        feed_label(32'h7FFF_FFFF);
        wait_idle();

        // width shrunk below the column count: frame restarts at pixel 0
        configure(32'd5, 13'd3, 13'd2);
        feed_label(32'd5);
        feed_label(32'd5);
        feed_label(32'd7);
        feed_label(32'd5);
        feed_label(32'd7);
        feed_label(32'd7);
        wait_idle();

        // stop mid-frame on the second row, then shrink again
        configure(32'd5, 13'd4, 13'd3);
        for (i = 0; i < 6; i++)
            feed_label((i % 3 == 1) ? 32'd4 : 32'd5);
        wait_idle();
        configure(32'd5, 13'd2, 13'd3);
        for (i = 0; i < 6; i++)
            feed_label((i == 2 || i == 3) ? 32'd5 : 32'd6);
        wait_idle();

        // back-pressure phase: one whole frame offered while the receiver holds off
        idle_on = 1'b1;
        configure(pick_region(), 13'd8, 13'd5);
        holds_asked++;
        for (i = 0; i < 40; i++)
            feed_label(pick_label(50));
        wait_idle();
        random_pixels = 40;

        while (random_pixels < RANDOM_PIXELS)
        begin
            kind      = $urandom_range(0, 9);
            match_pct = $urandom_range(15, 85);
            idle_on   = ($urandom_range(0, 3) != 0) && (random_pixels < RANDOM_PIXELS - 70);
            if (kind <= 6)
            begin
                cols = SIZE_W'($urandom_range(1, 8));
                rows = SIZE_W'($urandom_range(1, 6));
                if ($urandom_range(0, 4) == 0)
                    cols = SIZE_W'($urandom_range(9, 20));
                n = int'(cols) * int'(rows) * $urandom_range(1, 2);
            end
            else if (kind == 7)
            begin
                cols = SIZE_W'($urandom_range(1, 10));
                rows = SIZE_W'($urandom_range(1, 6));
                n = $urandom_range(1, int'(cols) * int'(rows));
            end
            else if (kind == 8)
            begin
                // wide image, only the start of it
                cols = pick_big();
                case ($urandom_range(0, 3))
                    0: rows = 13'd0;
                    1: rows = 13'd1;
                    2: rows = 13'd2;
                    default: rows = pick_big();
                endcase
                n = $urandom_range(4, 24);
            end
            else
            begin
                // narrow, tall image
                cols = SIZE_W'($urandom_range(0, 2));
                rows = pick_big();
                n = $urandom_range(4, 24);
            end
            configure(pick_region(), cols, rows);
            for (i = 0; i < n; i++)
                feed_label(pick_label(match_pct));
            wait_idle();
            random_pixels += n;
        end

        repeat (20) @(negedge clk);
        $display("run covered %0d label pixels, %0d mask items, %0d whole frames",
                 pixels_in, masks_seen, frames_seen);
        $display("%0d register writes across directed and random image sizes", reg_writes);
        if (mismatches == 0 && expected_masks.size() == 0)
            $display("interpixel_boundary_mask_core: match");
        else
            $display("interpixel_boundary_mask_core: mismatch");
        $finish;
    end

endmodule
